// ===== src/page_table_page_pool_allocator_macros.svh =====
// Assertion helpers shared by the allocator RTL.
`ifndef PAGE_TABLE_PAGE_POOL_ALLOCATOR_MACROS_SVH
`define PAGE_TABLE_PAGE_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTPA_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ptpa assertion failed");

// Next-cycle implication, disabled during reset.
`define PTPA_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ptpa assertion failed");

`endif

// ===== src/ptpa_pkg.sv =====
`timescale 1ns / 1ps

package ptpa_pkg;

	localparam int ADDR_W     = 64;
	localparam int LEAF_CNT_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] POOL_TOP  = 2'd0;
	localparam logic [1:0] POOL_MID  = 2'd1;
	localparam logic [1:0] POOL_LEAF = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EMPTY      = 2'd1;
	localparam logic [1:0] ST_MISALIGNED = 2'd2;
	localparam logic [1:0] ST_OUTSIDE    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TOP_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_BASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAF_BASE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic [1:0]        pool_sel;
		logic [ADDR_W-1:0] page_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] alloc_addr;
		logic [1:0]        status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

// ===== src/ptpa_ram.sv =====
`timescale 1ns / 1ps

module ptpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ptpa_ctrl.sv =====
`timescale 1ns / 1ps
`include "page_table_page_pool_allocator_macros.svh"

module ptpa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output ptpa_pkg::ctrl_cmd_t   cmd
);

	ptpa_pkg::state_t state_q;
	ptpa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptpa_pkg::S_IDLE: begin
				if (start) begin
					state_d = ptpa_pkg::S_EXEC;
				end
			end
			ptpa_pkg::S_EXEC: begin
				state_d = ptpa_pkg::S_IDLE;
			end
			default: begin
				state_d = ptpa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			ptpa_pkg::S_IDLE: begin
				cmd.capture = start;
			end
			ptpa_pkg::S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	`PTPA_ASSERT_NXT(a_capture_then_exec, clk, arst_n, cmd.capture, cmd.exec && busy)
	`PTPA_ASSERT_NXT(a_exec_single_cycle, clk, arst_n, cmd.exec, !cmd.exec)

endmodule

// ===== src/ptpa_dp.sv =====
`timescale 1ns / 1ps
`include "page_table_page_pool_allocator_macros.svh"

module ptpa_dp #(
	parameter int PAGE_BITS      = 12,
	parameter int TOP_POOL_ORDER = 2,
	parameter int MID_POOL_ORDER = 4,
	parameter int LEAF_POOL_MAX  = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ptpa_pkg::ctrl_cmd_t                 cmd,
	input  ptpa_pkg::req_t                      req,
	input  logic                                cfg_we,
	input  logic [ptpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptpa_pkg::ADDR_W-1:0]         cfg_wdata,
	output ptpa_pkg::rsp_t                      result,
	output logic                                done
);

	localparam int TopCap  = 1 << TOP_POOL_ORDER;
	localparam int MidCap  = 1 << MID_POOL_ORDER;
	localparam int LeafCap = LEAF_POOL_MAX;
	localparam int TopHw   = $clog2(TopCap + 1);
	localparam int MidHw   = $clog2(MidCap + 1);
	localparam int LeafHw  = $clog2(LeafCap + 1);
	localparam int TopIw   = (TopCap > 1) ? $clog2(TopCap) : 1;
	localparam int MidIw   = (MidCap > 1) ? $clog2(MidCap) : 1;
	localparam int LeafIw  = (LeafCap > 1) ? $clog2(LeafCap) : 1;
	localparam int SelW0   = (TopHw > MidHw) ? TopHw : MidHw;
	localparam int SelW    = (SelW0 > LeafHw) ? SelW0 : LeafHw;
	localparam int CntW    = (LeafHw > ptpa_pkg::LEAF_CNT_W) ? LeafHw : ptpa_pkg::LEAF_CNT_W;
	localparam int AW      = ptpa_pkg::ADDR_W;

	logic [AW-1:0]                     top_base_q;
	logic [AW-1:0]                     mid_base_q;
	logic [AW-1:0]                     leaf_base_q;
	logic [ptpa_pkg::LEAF_CNT_W-1:0]   leaf_cnt_q;

	logic [TopHw-1:0]  top_head_q;
	logic [TopHw-1:0]  top_issued_q;
	logic [MidHw-1:0]  mid_head_q;
	logic [MidHw-1:0]  mid_issued_q;
	logic [LeafHw-1:0] leaf_head_q;
	logic [LeafHw-1:0] leaf_issued_q;

	logic [TopHw-1:0]  top_rd;
	logic [MidHw-1:0]  mid_rd;
	logic [LeafHw-1:0] leaf_rd;

	ptpa_pkg::req_t    req_q;
	logic [AW-1:0]     diff_q;
	ptpa_pkg::rsp_t    result_q;
	logic              done_q;

	logic [AW-1:0]     cap_base;
	logic [CntW-1:0]   leaf_cnt_wide;
	logic [LeafHw-1:0] leaf_cnt;

	logic [SelW-1:0]   head_sel;
	logic [SelW-1:0]   cap_sel;
	logic [SelW-1:0]   count_sel;
	logic [SelW-1:0]   issued_sel;
	logic [SelW-1:0]   rd_sel;
	logic [AW-1:0]     base_sel;

	logic              is_alloc;
	logic              misaligned;
	logic [AW-1:0]     free_idx;
	logic              outside;
	logic              stack_ok;
	logic              fresh_ok;
	logic [SelW-1:0]   pop_idx;
	logic [AW-1:0]     alloc_addr_c;
	logic [1:0]        status_c;
	logic              take_stack;
	logic              take_fresh;
	logic              push;
	logic              sel_top;
	logic              sel_mid;
	logic              sel_leaf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_base_q  <= '0;
			mid_base_q  <= '0;
			leaf_base_q <= '0;
			leaf_cnt_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptpa_pkg::CFG_TOP_BASE:   top_base_q  <= cfg_wdata;
				ptpa_pkg::CFG_MID_BASE:   mid_base_q  <= cfg_wdata;
				ptpa_pkg::CFG_LEAF_BASE:  leaf_base_q <= cfg_wdata;
				ptpa_pkg::CFG_LEAF_COUNT: leaf_cnt_q  <= cfg_wdata[ptpa_pkg::LEAF_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (req.pool_sel)
			ptpa_pkg::POOL_TOP:  cap_base = top_base_q;
			ptpa_pkg::POOL_MID:  cap_base = mid_base_q;
			ptpa_pkg::POOL_LEAF: cap_base = leaf_base_q;
			default:             cap_base = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req;
			diff_q <= req.page_addr - cap_base;
		end
	end

	assign leaf_cnt_wide = (CntW'(leaf_cnt_q) > CntW'(LeafCap)) ? CntW'(LeafCap)
		: CntW'(leaf_cnt_q);
	assign leaf_cnt = LeafHw'(leaf_cnt_wide);

	always_comb begin
		case (req_q.pool_sel)
			ptpa_pkg::POOL_TOP: begin
				head_sel   = SelW'(top_head_q);
				cap_sel    = SelW'(TopCap);
				count_sel  = SelW'(TopCap);
				issued_sel = SelW'(top_issued_q);
				rd_sel     = SelW'(top_rd);
				base_sel   = top_base_q;
			end
			ptpa_pkg::POOL_MID: begin
				head_sel   = SelW'(mid_head_q);
				cap_sel    = SelW'(MidCap);
				count_sel  = SelW'(MidCap);
				issued_sel = SelW'(mid_issued_q);
				rd_sel     = SelW'(mid_rd);
				base_sel   = mid_base_q;
			end
			ptpa_pkg::POOL_LEAF: begin
				head_sel   = SelW'(leaf_head_q);
				cap_sel    = SelW'(LeafCap);
				count_sel  = SelW'(leaf_cnt);
				issued_sel = SelW'(leaf_issued_q);
				rd_sel     = SelW'(leaf_rd);
				base_sel   = leaf_base_q;
			end
			default: begin
				head_sel   = '0;
				cap_sel    = '0;
				count_sel  = '0;
				issued_sel = '0;
				rd_sel     = '0;
				base_sel   = '0;
			end
		endcase
	end

	assign is_alloc   = (req_q.req_type == ptpa_pkg::REQ_ALLOC);
	assign misaligned = |req_q.page_addr[PAGE_BITS-1:0];
	assign free_idx   = diff_q >> PAGE_BITS;
	assign outside    = (free_idx >= AW'(count_sel));
	assign stack_ok   = (head_sel < cap_sel);
	assign fresh_ok   = (issued_sel < count_sel);
	assign pop_idx    = stack_ok ? head_sel : (count_sel - SelW'(1) - issued_sel);
	assign alloc_addr_c = base_sel + (AW'(pop_idx) << PAGE_BITS);

	always_comb begin
		if (is_alloc) begin
			status_c = (stack_ok || fresh_ok) ? ptpa_pkg::ST_OK : ptpa_pkg::ST_EMPTY;
		end else if (misaligned) begin
			status_c = ptpa_pkg::ST_MISALIGNED;
		end else if (outside) begin
			status_c = ptpa_pkg::ST_OUTSIDE;
		end else begin
			status_c = ptpa_pkg::ST_OK;
		end
	end

	assign take_stack = cmd.exec && is_alloc && stack_ok;
	assign take_fresh = cmd.exec && is_alloc && !stack_ok && fresh_ok;
	assign push       = cmd.exec && !is_alloc && !misaligned && !outside;
	assign sel_top    = (req_q.pool_sel == ptpa_pkg::POOL_TOP);
	assign sel_mid    = (req_q.pool_sel == ptpa_pkg::POOL_MID);
	assign sel_leaf   = (req_q.pool_sel == ptpa_pkg::POOL_LEAF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_head_q    <= TopHw'(TopCap);
			top_issued_q  <= '0;
			mid_head_q    <= MidHw'(MidCap);
			mid_issued_q  <= '0;
			leaf_head_q   <= LeafHw'(LeafCap);
			leaf_issued_q <= '0;
		end else begin
			if (push && sel_top) begin
				top_head_q <= TopHw'(free_idx);
			end else if (take_stack && sel_top) begin
				top_head_q <= top_rd;
			end
			if (take_fresh && sel_top) begin
				top_issued_q <= top_issued_q + TopHw'(1);
			end
			if (push && sel_mid) begin
				mid_head_q <= MidHw'(free_idx);
			end else if (take_stack && sel_mid) begin
				mid_head_q <= mid_rd;
			end
			if (take_fresh && sel_mid) begin
				mid_issued_q <= mid_issued_q + MidHw'(1);
			end
			if (push && sel_leaf) begin
				leaf_head_q <= LeafHw'(free_idx);
			end else if (take_stack && sel_leaf) begin
				leaf_head_q <= leaf_rd;
			end
			if (take_fresh && sel_leaf) begin
				leaf_issued_q <= leaf_issued_q + LeafHw'(1);
			end
		end
	end

	ptpa_ram #(.WIDTH(TopHw), .DEPTH(TopCap)) u_top_links (
		.clk   (clk),
		.we    (push && sel_top),
		.waddr (TopIw'(free_idx)),
		.wdata (top_head_q),
		.re    (cmd.capture),
		.raddr (TopIw'(top_head_q)),
		.rdata (top_rd)
	);

	ptpa_ram #(.WIDTH(MidHw), .DEPTH(MidCap)) u_mid_links (
		.clk   (clk),
		.we    (push && sel_mid),
		.waddr (MidIw'(free_idx)),
		.wdata (mid_head_q),
		.re    (cmd.capture),
		.raddr (MidIw'(mid_head_q)),
		.rdata (mid_rd)
	);

	ptpa_ram #(.WIDTH(LeafHw), .DEPTH(LeafCap)) u_leaf_links (
		.clk   (clk),
		.we    (push && sel_leaf),
		.waddr (LeafIw'(free_idx)),
		.wdata (leaf_head_q),
		.re    (cmd.capture),
		.raddr (LeafIw'(leaf_head_q)),
		.rdata (leaf_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q.alloc_addr <= (is_alloc && (stack_ok || fresh_ok)) ? alloc_addr_c : '0;
			result_q.status     <= status_c;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	`PTPA_ASSERT_NXT(a_exec_gives_done, clk, arst_n, cmd.exec, done_q)
	`PTPA_ASSERT_IMP(a_fail_zero_addr, clk, arst_n, done_q && (result_q.status != ptpa_pkg::ST_OK), result_q.alloc_addr == '0)
	`PTPA_ASSERT_IMP(a_top_head_bound, clk, arst_n, 1'b1, top_head_q <= TopHw'(TopCap))

endmodule

// ===== src/page_table_page_pool_allocator.sv =====
`timescale 1ns / 1ps
// Start is captured in S_IDLE, the request runs in S_EXEC and done is registered
// from S_EXEC; start is ignored while busy. Busy is high for the cycle in which
// the link memory read for the pool head is consumed and the write-back happens.
// Reset: asynchronous, active low; pools empty of freed pages, nothing issued.
// Results cannot be stalled: each is shown for exactly one cycle with done.

module page_table_page_pool_allocator #(
	parameter int PAGE_BITS      = 12,
	parameter int TOP_POOL_ORDER = 2,
	parameter int MID_POOL_ORDER = 4,
	parameter int LEAF_POOL_MAX  = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  ptpa_pkg::req_t                  req,
	output logic                            done,
	output ptpa_pkg::rsp_t                  result,
	input  logic                            cfg_we,
	input  logic [ptpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptpa_pkg::ADDR_W-1:0]     cfg_wdata
);

	ptpa_pkg::ctrl_cmd_t cmd;

	ptpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ptpa_dp #(
		.PAGE_BITS      (PAGE_BITS),
		.TOP_POOL_ORDER (TOP_POOL_ORDER),
		.MID_POOL_ORDER (MID_POOL_ORDER),
		.LEAF_POOL_MAX  (LEAF_POOL_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.result    (result),
		.done      (done)
	);

endmodule
